>>> rtl/core/isv_pkg.sv
// Shared types and constants of the interpolating sample voice.
`timescale 1ns / 1ps
package isv_pkg;

    localparam int FRAME_W   = 15;
    localparam int SPEED_W   = 20;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 15;

    localparam logic [2:0] MODE_RENDER  = 3'd0;
    localparam logic [2:0] MODE_LOAD    = 3'd1;
    localparam logic [2:0] MODE_TRIGGER = 3'd2;
    localparam logic [2:0] MODE_STOP    = 3'd3;
    localparam logic [2:0] MODE_SPEED   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOADED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 3'd4;

    typedef struct packed {
        logic [2:0]          mode;
        logic [13:0]         sample_address;
        logic signed [15:0]  sample_left;
        logic signed [15:0]  sample_right;
        logic [SPEED_W-1:0]  speed;
        logic [15:0]         gain;
        logic signed [23:0]  mix_left;
        logic signed [23:0]  mix_right;
    } t_in;

    typedef struct packed {
        logic signed [23:0] out_left;
        logic signed [23:0] out_right;
        logic               playing;
    } t_out;

    typedef struct packed {
        logic accept;
        logic rd;
        logic mul;
        logic sum;
        logic gain;
        logic fin;
        logic wrap;
    } t_cmd;

    typedef struct packed {
        logic render_go;
        logic render_wrap;
        logic pos_ge_end;
        logic fin_wrap;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/core/isv_ctrl.sv
// Sequencer of the sample voice: accepts beats and steps the datapath.
`timescale 1ns / 1ps
module isv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  isv_pkg::t_sts i_sts,
    output isv_pkg::t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PWRAP = 8'b0000_0010,
        S_RD    = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_SUM   = 8'b0001_0000,
        S_GAIN  = 8'b0010_0000,
        S_FIN   = 8'b0100_0000,
        S_WRAP  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_stall = !((r_state == S_IDLE) && i_sts.out_free);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd        = '0;
        o_cmd.accept = accept;
        o_cmd.rd     = (r_state == S_RD);
        o_cmd.mul    = (r_state == S_MUL);
        o_cmd.sum    = (r_state == S_SUM);
        o_cmd.gain   = (r_state == S_GAIN);
        o_cmd.fin    = (r_state == S_FIN);
        o_cmd.wrap   = ((r_state == S_WRAP) || (r_state == S_PWRAP)) && i_sts.pos_ge_end;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_sts.render_wrap) begin
                    n_state = S_PWRAP;
                end else if (accept && i_sts.render_go) begin
                    n_state = S_RD;
                end
            end
            S_PWRAP: begin
                if (!i_sts.pos_ge_end) n_state = S_RD;
            end
            S_RD:   n_state = S_MUL;
            S_MUL:  n_state = S_SUM;
            S_SUM:  n_state = S_GAIN;
            S_GAIN: n_state = S_FIN;
            S_FIN:  n_state = i_sts.fin_wrap ? S_WRAP : S_IDLE;
            S_WRAP: begin
                if (!i_sts.pos_ge_end) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n) $onehot(r_state))
        else $error("state not one-hot");
    a_fin_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN |=> (r_state == S_IDLE || r_state == S_WRAP))
        else $error("bad exit from finish");
    a_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_sts.render_go) |=> (r_state == S_RD))
        else $error("render beat did not start a read");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input taken while busy");

endmodule

>>> rtl/core/isv_dp.sv
// Datapath of the sample voice: frame store, position, speed ramp, mixer.
`timescale 1ns / 1ps
module isv_dp #(
    parameter int SAMPLE_FRAMES = 16384,
    parameter int RAMP_FRAMES   = 64,
    parameter int FRACTION_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  isv_pkg::t_in                      i_in,
    input  logic                              i_cfg_we,
    input  logic [isv_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [isv_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  isv_pkg::t_cmd                     i_cmd,
    output isv_pkg::t_sts                     o_sts,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output isv_pkg::t_out                     o_out
);

    localparam int F   = FRACTION_BITS;
    localparam int FW  = isv_pkg::FRAME_W;
    localparam int SW  = isv_pkg::SPEED_W;
    localparam int AW  = (SAMPLE_FRAMES > 1) ? $clog2(SAMPLE_FRAMES) : 1;
    localparam int PW  = FW + F + 1;
    localparam int RW  = $clog2(RAMP_FRAMES + 1);
    localparam int PRW = 16 + F + 2;
    localparam int GW  = PRW + 17;
    localparam int RK  = SW + 1 + $clog2(RAMP_FRAMES);
    localparam int QW  = 2 * SW + 3;
    localparam logic [SW+1:0] RECIP =
        (SW+2)'(((64'd1 << RK) + 64'(RAMP_FRAMES) - 64'd1) / 64'(RAMP_FRAMES));
    localparam logic signed [GW-1:0] HALF    = GW'(1) <<< (F + 14);
    localparam logic signed [GW-1:0] SAT_MAX = GW'(8388607);
    localparam logic signed [GW-1:0] SAT_MIN = -GW'(8388608);

    logic [31:0] r_mem [SAMPLE_FRAMES];

    logic [FW-1:0]          r_start, r_end, r_loaded;
    logic                   r_loop, r_stereo;
    logic [PW-1:0]          r_pos;
    logic                   r_active;
    logic [SW-1:0]          r_cur, r_tgt;
    logic signed [SW:0]     r_step;
    logic [RW-1:0]          r_ramp;
    logic [15:0]            r_gain;
    logic signed [23:0]     r_mix_l, r_mix_r;
    logic [31:0]            r_rd0, r_rd1;
    logic signed [PRW-1:0]  r_p0l, r_p1l, r_p0r, r_p1r, r_vl, r_vr;
    logic signed [GW-1:0]   r_gl, r_gr;
    logic                   r_out_valid;
    isv_pkg::t_out          r_out;

    logic [FW-1:0]          lim, s, e, i0, i1;
    logic                   rng_ok;
    logic [PW-1:0]          endp, stp, len, pos_next;
    logic [F-1:0]           t;
    logic [F:0]             u;
    logic signed [SW:0]     d, step_new;
    logic [SW:0]            mag, quo;
    logic [QW-1:0]          qprod;
    logic signed [GW-1:0]   cl, cr, sl, sr;
    logic signed [23:0]     fl, fr;
    logic                   out_free, is_render, nogo, render_stop, out_load;

    assign lim    = (32'(r_loaded) < SAMPLE_FRAMES) ? r_loaded : FW'(SAMPLE_FRAMES);
    assign rng_ok = (r_loaded != '0) && (r_start < r_end) && (r_end <= lim);
    assign s      = rng_ok ? r_start : '0;
    assign e      = rng_ok ? r_end : '0;
    assign endp   = PW'(e) << F;
    assign stp    = PW'(s) << F;
    assign len    = endp - stp;
    assign pos_next = r_pos + PW'(r_cur);

    assign i0 = FW'(r_pos >> F);
    assign t  = r_pos[F-1:0];
    assign u  = ((F+1)'(1) << F) - (F+1)'(t);
    assign i1 = ((17'(i0) + 17'd1) < 17'(e)) ? FW'(i0 + FW'(1)) : (r_loop ? s : i0);

    assign out_free    = !r_out_valid || !i_out_stall;
    assign is_render   = (i_in.mode == isv_pkg::MODE_RENDER);
    assign nogo        = !r_active || (r_cur == '0);
    assign render_stop = nogo || ((r_pos >= endp) && !(r_loop && (s < e)));
    assign out_load    = i_cmd.fin || (i_cmd.accept && (!is_render || render_stop));

    assign o_sts.out_free    = out_free;
    assign o_sts.render_go   = is_render && !nogo && (r_pos < endp);
    assign o_sts.render_wrap = is_render && !nogo && (r_pos >= endp) && r_loop && (s < e);
    assign o_sts.pos_ge_end  = r_pos >= endp;
    assign o_sts.fin_wrap    = (pos_next >= endp) && r_loop && (s < e);

    assign d        = $signed({1'b0, i_in.speed}) - $signed({1'b0, r_cur});
    assign mag      = d[SW] ? (SW+1)'(-d) : (SW+1)'(d);
    assign qprod    = QW'(mag) * QW'(RECIP);
    assign quo      = (SW+1)'(qprod >> RK);
    assign step_new = d[SW] ? -$signed(quo) : $signed(quo);

    assign cl = r_gl >>> (F + 15);
    assign cr = r_stereo ? (r_gr >>> (F + 15)) : cl;
    assign sl = cl + GW'(r_mix_l);
    assign sr = cr + GW'(r_mix_r);
    assign fl = (sl > SAT_MAX) ? 24'sd8388607 : ((sl < SAT_MIN) ? -24'sd8388608 : 24'(sl));
    assign fr = (sr > SAT_MAX) ? 24'sd8388607 : ((sr < SAT_MIN) ? -24'sd8388608 : 24'(sr));

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_in.mode == isv_pkg::MODE_LOAD)
                && (32'(i_in.sample_address) < SAMPLE_FRAMES)) begin
            r_mem[AW'(i_in.sample_address)] <= {i_in.sample_right, i_in.sample_left};
        end
        if (i_cmd.rd) begin
            r_rd0 <= r_mem[AW'(i0)];
            r_rd1 <= r_mem[AW'(i1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_gain  <= i_in.gain;
            r_mix_l <= i_in.mix_left;
            r_mix_r <= i_in.mix_right;
        end
        if (i_cmd.mul) begin
            r_p0l <= PRW'($signed(r_rd0[15:0])  * $signed({1'b0, u}));
            r_p1l <= PRW'($signed(r_rd1[15:0])  * $signed({2'b0, t}));
            r_p0r <= PRW'($signed(r_rd0[31:16]) * $signed({1'b0, u}));
            r_p1r <= PRW'($signed(r_rd1[31:16]) * $signed({2'b0, t}));
        end
        if (i_cmd.sum) begin
            r_vl <= r_p0l + r_p1l;
            r_vr <= r_p0r + r_p1r;
        end
        if (i_cmd.gain) begin
            r_gl <= GW'(r_vl * $signed({1'b0, r_gain})) + HALF;
            r_gr <= GW'(r_vr * $signed({1'b0, r_gain})) + HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_end       <= '0;
            r_loaded    <= '0;
            r_loop      <= 1'b0;
            r_stereo    <= 1'b0;
            r_pos       <= '0;
            r_active    <= 1'b0;
            r_cur       <= '0;
            r_tgt       <= '0;
            r_step      <= '0;
            r_ramp      <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    isv_pkg::CFG_START:  begin r_start  <= i_cfg_data; r_active <= 1'b0; end
                    isv_pkg::CFG_END:    begin r_end    <= i_cfg_data; r_active <= 1'b0; end
                    isv_pkg::CFG_LOADED: begin r_loaded <= i_cfg_data; r_active <= 1'b0; end
                    isv_pkg::CFG_LOOP:   begin r_loop   <= i_cfg_data[0]; r_active <= 1'b0; end
                    isv_pkg::CFG_STEREO: begin r_stereo <= i_cfg_data[0]; r_active <= 1'b0; end
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                unique case (i_in.mode)
                    isv_pkg::MODE_TRIGGER: begin
                        r_pos    <= stp;
                        r_active <= (e > s) && (r_cur != '0);
                        r_out    <= '{out_left: '0, out_right: '0,
                                      playing: (e > s) && (r_cur != '0)};
                    end
                    isv_pkg::MODE_STOP: begin
                        r_active <= 1'b0;
                        r_out    <= '0;
                    end
                    isv_pkg::MODE_SPEED: begin
                        r_tgt <= i_in.speed;
                        if (!r_active || (i_in.speed == '0) || (i_in.speed == r_cur)) begin
                            r_cur  <= i_in.speed;
                            r_step <= '0;
                            r_ramp <= '0;
                        end else begin
                            r_ramp <= RW'(RAMP_FRAMES);
                            r_step <= step_new;
                        end
                        r_out <= '{out_left: '0, out_right: '0, playing: r_active};
                    end
                    isv_pkg::MODE_RENDER: begin
                        if (render_stop) begin
                            r_active <= 1'b0;
                            r_out    <= '{out_left: i_in.mix_left,
                                          out_right: i_in.mix_right, playing: 1'b0};
                        end
                    end
                    default: begin
                        r_out <= '{out_left: '0, out_right: '0, playing: r_active};
                    end
                endcase
            end
            if (i_cmd.wrap) begin
                r_pos <= r_pos - len;
            end
            if (i_cmd.fin) begin
                r_pos <= pos_next;
                if (r_ramp != '0) begin
                    r_ramp <= r_ramp - RW'(1);
                    if (r_ramp == RW'(1)) begin
                        r_cur <= r_tgt;
                    end else begin
                        r_cur <= SW'($signed({1'b0, r_cur}) + r_step);
                    end
                end
                if ((pos_next >= endp) && !(r_loop && (s < e))) begin
                    r_active <= 1'b0;
                end
                r_out <= '{out_left: fl, out_right: fr,
                           playing: r_active && !((pos_next >= endp) && !(r_loop && (s < e)))};
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> rtl/core/interpolating_sample_voice_top.sv
// Top level of the interpolating sample voice.
// Load, trigger, stop and speed beats are taken in idle; their result appears the next cycle.
// A render beat is accepted, then steps through store read, interpolation multiply, sum,
// gain multiply and mix until its result is registered; the next beat is taken back in idle.
// A loop wrap subtracts the range length until the position is below the end, before or after the render.
// One beat in flight; a held result stalls input. Sync active-low reset clears state and config.
`timescale 1ns / 1ps
module interpolating_sample_voice_top #(
    parameter int SAMPLE_FRAMES = 16384,
    parameter int RAMP_FRAMES   = 64,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  isv_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output isv_pkg::t_out                 o_out,
    input  logic                          i_cfg_we,
    input  logic [isv_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [isv_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    isv_pkg::t_cmd cmd;
    isv_pkg::t_sts sts;

    isv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    isv_dp #(
        .SAMPLE_FRAMES (SAMPLE_FRAMES),
        .RAMP_FRAMES   (RAMP_FRAMES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
